// ----- sv/bcc_pkg.sv -----
`default_nettype none
package bcc_pkg;

    localparam int TICK_W       = 8;
    localparam int DVD_W        = TICK_W + 1;
    localparam int RATIO_W      = 4;
    localparam int HOUR_W       = 5;
    localparam int MIN_W        = 6;
    localparam int SEC_W        = 6;
    localparam int MODE_W       = 2;
    localparam int REQ_W        = 2;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int HOLD_COUNT_WIDTH_DEF = 8;
    localparam int MOD_CNT_W    = 4;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_MODE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 2'd2;

    localparam logic [1:0] REG_TPS        = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_NORM_RATIO = 2'd2;
    localparam logic [1:0] REG_SAVE_RATIO = 2'd3;

    localparam logic [TICK_W-1:0]  TPS_RST        = 8'd128;
    localparam logic [TICK_W-1:0]  LONG_PRESS_RST = 8'd40;
    localparam logic [RATIO_W-1:0] NORM_RATIO_RST = 4'd1;
    localparam logic [RATIO_W-1:0] SAVE_RATIO_RST = 4'd3;
    localparam logic [MIN_W-1:0]   MIN_RST        = 6'd10;
    localparam logic [TICK_W-1:0]  TICK_RST       = 8'd128;

    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TICK_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] rem;
    } t_mod_rsp;

endpackage
`default_nettype wire

// ----- sv/binary_clock_controller_unit.sv -----
// Binary LED clock controller.
// Input channel (i_valid / o_ready) carries one request beat: a tick, a mode
// button press, or a sample of the up and down button levels. Output channel
// (o_valid / i_ready) returns one result beat per request: LED patterns,
// current time, power mode and sleep request.
// One request is worked at a time; o_ready is high only while the sequencer
// is idle. A tick passes through the shared 9-step restoring remainder unit
// twice (next tick modulo ticks per second, then tick count modulo blank
// ratio); a mode press, a button sample and an unused request type pass
// through it once, for the blank ratio. The next request is accepted once
// the result is registered and the sequencer is back in idle.
// The result sits in an output register, so the next request is accepted
// while a result still waits; a stalled receiver holds the finished result
// and blocks only the following one at its final step.
// Configuration is written through the APB port, registers at byte
// addresses 0, 4, 8, 12; pready is always high and reads return the values.
// Synchronous active-low reset restores the time to 00:10:00, normal mode
// and the register defaults, and empties the output register.
`default_nettype none
module binary_clock_controller_unit
    import bcc_pkg::*;
#(
    parameter int HOLD_COUNT_WIDTH = HOLD_COUNT_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic               i_up_level,
    input  wire logic               i_down_level,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [HOUR_W-1:0]       o_hour_leds,
    output logic [MIN_W-1:0]        o_minute_leds,
    output logic                    o_second_led,
    output logic [HOUR_W-1:0]       o_hours_now,
    output logic [MIN_W-1:0]        o_minutes_now,
    output logic [SEC_W-1:0]        o_seconds_now,
    output logic [MODE_W-1:0]       o_mode_now,
    output logic                    o_sleep_request,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int HW = HOLD_COUNT_WIDTH;
    localparam int CW = (HW > TICK_W) ? HW : TICK_W;
    localparam logic [HW-1:0] HOLD_MAX = {HW{1'b1}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TMOD   = 4'd1;
    localparam logic [3:0] S_SEC    = 4'd2;
    localparam logic [3:0] S_UPH    = 4'd3;
    localparam logic [3:0] S_DNH    = 4'd4;
    localparam logic [3:0] S_MODE   = 4'd5;
    localparam logic [3:0] S_SUP    = 4'd6;
    localparam logic [3:0] S_SDN    = 4'd7;
    localparam logic [3:0] S_BSTART = 4'd8;
    localparam logic [3:0] S_BMOD   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    typedef struct packed {
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;
        logic [SEC_W-1:0]  s;
    } t_time;

    function automatic t_time f_min_up(t_time t);
        t_time r;
        r = t;
        if (t.m >= MIN_MAX) begin
            r.m = '0;
            r.h = (t.h >= HOUR_MAX) ? '0 : t.h + 1'b1;
        end else begin
            r.m = t.m + 1'b1;
        end
        return r;
    endfunction

    function automatic t_time f_min_dn(t_time t);
        t_time r;
        r = t;
        if (t.m == '0 || t.m > MIN_MAX) begin
            r.m = MIN_MAX;
            r.h = (t.h == '0 || t.h > HOUR_MAX) ? HOUR_MAX : t.h - 1'b1;
        end else begin
            r.m = t.m - 1'b1;
        end
        return r;
    endfunction

    function automatic t_time f_sec_up(t_time t);
        t_time r;
        r = t;
        if (t.s >= SEC_MAX) begin
            r   = f_min_up(t);
            r.s = '0;
        end else begin
            r.s = t.s + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] f_hold_inc(logic [HW-1:0] v);
        return (v == HOLD_MAX) ? HOLD_MAX : v + 1'b1;
    endfunction

    logic [TICK_W-1:0]  r_tps;
    logic [TICK_W-1:0]  r_long_press;
    logic [RATIO_W-1:0] r_norm_ratio;
    logic [RATIO_W-1:0] r_save_ratio;

    logic [3:0]         r_state;
    logic               r_up;
    logic               r_dn;
    logic               r_even;
    logic [TICK_W-1:0]  r_trem;

    t_time              r_time;
    logic [TICK_W-1:0]  r_tick;
    logic [MODE_W-1:0]  r_mode;
    logic [RATIO_W-1:0] r_ratio;
    logic               r_up_last;
    logic               r_dn_last;
    logic               r_up_held;
    logic               r_dn_held;
    logic [HW-1:0]      r_up_hold;
    logic [HW-1:0]      r_dn_hold;
    logic               r_shown;

    logic               r_out_valid;
    logic [HOUR_W-1:0]  r_hour_leds;
    logic [MIN_W-1:0]   r_minute_leds;
    logic               r_second_led;
    t_time              r_out_time;
    logic [MODE_W-1:0]  r_out_mode;

    t_mod_req           mod_req;
    t_mod_rsp           mod_rsp;

    logic               in_beat;
    logic               cfg_wr;
    logic [TICK_W-1:0]  tps_eff;
    logic [TICK_W-1:0]  ratio_eff;
    logic [DVD_W-1:0]   tick_next;
    logic [HW-1:0]      up_inc;
    logic [HW-1:0]      dn_inc;

    assign in_beat   = i_valid && o_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign tps_eff   = (r_tps == '0) ? TICK_W'(1) : r_tps;
    assign ratio_eff = (r_ratio == '0) ? TICK_W'(1) : TICK_W'(r_ratio);
    assign tick_next = {1'b0, r_tick} + DVD_W'(1);
    assign up_inc    = f_hold_inc(r_up_hold);
    assign dn_inc    = f_hold_inc(r_dn_hold);

    always_comb begin
        mod_req.start    = 1'b0;
        mod_req.dividend = tick_next;
        mod_req.divisor  = tps_eff;
        if (r_state == S_IDLE && in_beat && i_req_type == REQ_TICK) begin
            mod_req.start = 1'b1;
        end else if (r_state == S_BSTART) begin
            mod_req.start    = 1'b1;
            mod_req.dividend = {1'b0, r_tick};
            mod_req.divisor  = ratio_eff;
        end
    end

    bcc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TPS_RST;
            r_long_press <= LONG_PRESS_RST;
            r_norm_ratio <= NORM_RATIO_RST;
            r_save_ratio <= SAVE_RATIO_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TPS:        r_tps        <= pwdata[TICK_W-1:0];
                REG_LONG_PRESS: r_long_press <= pwdata[TICK_W-1:0];
                REG_NORM_RATIO: r_norm_ratio <= pwdata[RATIO_W-1:0];
                REG_SAVE_RATIO: r_save_ratio <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TPS:        prdata = PDATA_W'(r_tps);
            REG_LONG_PRESS: prdata = PDATA_W'(r_long_press);
            REG_NORM_RATIO: prdata = PDATA_W'(r_norm_ratio);
            REG_SAVE_RATIO: prdata = PDATA_W'(r_save_ratio);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '{h: '0, m: MIN_RST, s: '0};
            r_tick      <= TICK_RST;
            r_mode      <= MODE_NORMAL;
            r_ratio     <= NORM_RATIO_RST;
            r_up_last   <= 1'b1;
            r_dn_last   <= 1'b1;
            r_up_held   <= 1'b0;
            r_dn_held   <= 1'b0;
            r_up_hold   <= '0;
            r_dn_hold   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_up   <= i_up_level;
                        r_dn   <= i_down_level;
                        r_even <= ~tick_next[0];
                        case (i_req_type)
                            REQ_TICK:   r_state <= S_TMOD;
                            REQ_MODE:   r_state <= S_MODE;
                            REQ_SAMPLE: r_state <= S_SUP;
                            default:    r_state <= S_BSTART;
                        endcase
                    end
                end
                S_TMOD: begin
                    if (mod_rsp.done) begin
                        r_trem  <= mod_rsp.rem;
                        r_state <= S_SEC;
                    end
                end
                S_SEC: begin
                    if (r_trem == '0) begin
                        r_time <= f_sec_up(r_time);
                    end
                    r_state <= S_UPH;
                end
                S_UPH: begin
                    if (r_up_held) begin
                        r_dn_hold <= '0;
                        r_up_hold <= up_inc;
                        if (CW'(up_inc) > CW'(r_long_press) && r_even) begin
                            r_time <= f_min_up(r_time);
                        end
                    end else begin
                        r_up_hold <= '0;
                    end
                    r_state <= S_DNH;
                end
                S_DNH: begin
                    if (r_dn_held) begin
                        r_up_hold <= '0;
                        r_dn_hold <= dn_inc;
                        if (CW'(dn_inc) > CW'(r_long_press) && r_even) begin
                            r_time <= f_min_dn(r_time);
                        end
                    end else begin
                        r_dn_hold <= '0;
                    end
                    r_tick  <= r_trem;
                    r_state <= S_BSTART;
                end
                S_MODE: begin
                    case (r_mode)
                        MODE_NORMAL: begin
                            r_mode  <= MODE_SAVE;
                            r_ratio <= r_save_ratio;
                        end
                        MODE_SAVE: begin
                            r_mode <= MODE_SLEEP;
                        end
                        default: begin
                            r_mode  <= MODE_NORMAL;
                            r_ratio <= r_norm_ratio;
                        end
                    endcase
                    r_state <= S_BSTART;
                end
                S_SUP: begin
                    if (r_up && !r_up_last) begin
                        r_time    <= f_min_up(r_time);
                        r_up_held <= 1'b0;
                    end else if (!r_up && r_up_last) begin
                        r_up_held <= 1'b1;
                    end
                    r_up_last <= r_up;
                    r_state   <= S_SDN;
                end
                S_SDN: begin
                    if (r_dn && !r_dn_last) begin
                        r_time    <= f_min_dn(r_time);
                        r_dn_held <= 1'b0;
                    end else if (!r_dn && r_dn_last) begin
                        r_dn_held <= 1'b1;
                    end
                    r_dn_last <= r_dn;
                    r_state   <= S_BSTART;
                end
                S_BSTART: begin
                    r_state <= S_BMOD;
                end
                S_BMOD: begin
                    if (mod_rsp.done) begin
                        r_shown <= (mod_rsp.rem == '0) && (r_mode != MODE_SLEEP);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_hour_leds   <= r_shown ? r_time.h : '0;
                        r_minute_leds <= r_shown ? r_time.m : '0;
                        r_second_led  <= r_shown ? r_time.s[0] : 1'b0;
                        r_out_time    <= r_time;
                        r_out_mode    <= r_mode;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_hour_leds     = r_hour_leds;
    assign o_minute_leds   = r_minute_leds;
    assign o_second_led    = r_second_led;
    assign o_hours_now     = r_out_time.h;
    assign o_minutes_now   = r_out_time.m;
    assign o_seconds_now   = r_out_time.s;
    assign o_mode_now      = r_out_mode;
    assign o_sleep_request = (r_out_mode == MODE_SLEEP);

endmodule
`default_nettype wire

// ----- sv/bcc_mod_unit.sv -----
`default_nettype none
module bcc_mod_unit
    import bcc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_dvd;
    logic [TICK_W-1:0]    r_dvs;
    logic [TICK_W-1:0]    r_rem;
    logic [DVD_W-1:0]     trial;
    logic                 fits;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_rem <= fits ? TICK_W'(trial - {1'b0, r_dvs}) : trial[TICK_W-1:0];
                if (r_cnt == MOD_CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire
